// ===== src/sbt_pkg.sv =====
// Shared types, codes and defaults for the sorted breakpoint table.
package sbt_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int ADDR_W          = 32;
  localparam int FUNC_W          = 2;

  localparam logic [FUNC_W-1:0] FUNC_SET     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_UNSET   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_NEAREST = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT_UP,
    ST_SHIFT_DN
  } sbt_state_e;

  // Controller -> datapath
  typedef struct packed {
    logic load;       // capture item, clear scan results
    logic scan_step;  // read entry at pointer, advance
    logic init_up;    // pointer := count (insert shift)
    logic init_dn;    // pointer := insert/match position (remove shift)
    logic step_up;    // move entry ptr-1 to ptr
    logic step_dn;    // move entry ptr+1 to ptr
    logic write_new;  // write new entry at position, count++
    logic dec_count;  // count--
    logic respond;    // load result registers, pulse done
    logic refused;    // status bit for this result
  } sbt_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              create;
    logic              eq;         // address present
    logic              full;
    logic              scan_end;
    logic              up_end;
    logic              dn_end;
    logic              pipe_busy;  // read or move still in flight
  } sbt_stat_t;

endpackage

// ===== src/sbt_ctrl.sv =====
// Sequencer for scan, shift and response of the breakpoint table.
module sbt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  sbt_pkg::sbt_stat_t stat_i,
  output sbt_pkg::sbt_cmd_t  cmd_o,
  output logic              busy_o
);

  sbt_pkg::sbt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      sbt_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = sbt_pkg::ST_SCAN;
        end
      end
      sbt_pkg::ST_SCAN: begin
        if (!stat_i.scan_end) begin
          cmd_o.scan_step = 1'b1;
        end else if (!stat_i.pipe_busy) begin
          state_d = sbt_pkg::ST_IDLE;
          if (stat_i.func == sbt_pkg::FUNC_SET && !stat_i.eq && stat_i.create) begin
            if (stat_i.full) begin
              cmd_o.respond = 1'b1;
              cmd_o.refused = 1'b1;
            end else begin
              cmd_o.init_up = 1'b1;
              state_d       = sbt_pkg::ST_SHIFT_UP;
            end
          end else if (stat_i.func == sbt_pkg::FUNC_UNSET && stat_i.eq) begin
            cmd_o.init_dn = 1'b1;
            state_d       = sbt_pkg::ST_SHIFT_DN;
          end else begin
            cmd_o.respond = 1'b1;
          end
        end
      end
      sbt_pkg::ST_SHIFT_UP: begin
        if (!stat_i.up_end) begin
          cmd_o.step_up = 1'b1;
        end else if (!stat_i.pipe_busy) begin
          cmd_o.write_new = 1'b1;
          cmd_o.respond   = 1'b1;
          state_d         = sbt_pkg::ST_IDLE;
        end
      end
      sbt_pkg::ST_SHIFT_DN: begin
        if (!stat_i.dn_end) begin
          cmd_o.step_dn = 1'b1;
        end else if (!stat_i.pipe_busy) begin
          cmd_o.dec_count = 1'b1;
          cmd_o.respond   = 1'b1;
          state_d         = sbt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sbt_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != sbt_pkg::ST_IDLE);

endmodule

// ===== src/sbt_datapath.sv =====
// Entry memory, scan compare, shift pipeline and result registers.
module sbt_datapath #(
  parameter int MaxEntries = sbt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sbt_pkg::sbt_cmd_t          cmd_i,
  output sbt_pkg::sbt_stat_t         stat_o,
  input  logic [sbt_pkg::FUNC_W-1:0] func_i,
  input  logic [sbt_pkg::ADDR_W-1:0] address_i,
  input  logic                       hit_flag_i,
  input  logic                       create_if_missing_i,
  output logic                       done_o,
  output logic                       found_o,
  output logic [sbt_pkg::ADDR_W-1:0] entry_address_o,
  output logic                       entry_hit_o,
  output logic                       status_o
);

  localparam int IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CntW = $clog2(MaxEntries + 1);
  localparam int EntW = sbt_pkg::ADDR_W + 1;  // {address, hit}

  // entry storage, no reset: only entries below count are ever read
  logic [EntW-1:0] mem_q [MaxEntries];
  logic [EntW-1:0] rd_data_q;

  // control
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic            scan_vld_q, wr_pend_q, done_q;

  // payload
  logic [sbt_pkg::FUNC_W-1:0] func_q;
  logic [sbt_pkg::ADDR_W-1:0] addr_q;
  logic                       hit_q, create_q;
  logic [IdxW-1:0]            wr_idx_q;
  logic [CntW-1:0]            lt_cnt_q;
  logic                       eq_q, floor_vld_q, floor_hit_q;
  logic [sbt_pkg::ADDR_W-1:0] floor_addr_q;
  logic                       found_q, entry_hit_q, status_q;
  logic [sbt_pkg::ADDR_W-1:0] entry_addr_q;

  logic [CntW-1:0]            ptr_inc, ptr_dec, rd_ptr;
  logic                       rd_en, wr_en;
  logic [IdxW-1:0]            wr_idx;
  logic [EntW-1:0]            wr_data;
  logic [sbt_pkg::ADDR_W-1:0] rd_addr;
  logic                       rd_hit, found_d;

  assign ptr_inc = ptr_q + CntW'(1);
  assign ptr_dec = ptr_q - CntW'(1);
  assign rd_addr = rd_data_q[EntW-1:1];
  assign rd_hit  = rd_data_q[0];

  always_comb begin
    rd_en  = cmd_i.scan_step | cmd_i.step_up | cmd_i.step_dn;
    rd_ptr = ptr_q;
    if (cmd_i.step_up) begin
      rd_ptr = ptr_dec;
    end else if (cmd_i.step_dn) begin
      rd_ptr = ptr_inc;
    end
  end

  always_comb begin
    wr_en   = wr_pend_q;
    wr_idx  = wr_idx_q;
    wr_data = rd_data_q;
    if (cmd_i.write_new) begin
      wr_en   = 1'b1;
      wr_idx  = lt_cnt_q[IdxW-1:0];
      wr_data = {addr_q, hit_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_ptr[IdxW-1:0]];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.write_new) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.dec_count) begin
      count_d = count_q - CntW'(1);
    end
    ptr_d = ptr_q;
    if (cmd_i.load) begin
      ptr_d = '0;
    end else if (cmd_i.init_up) begin
      ptr_d = count_q;
    end else if (cmd_i.init_dn) begin
      ptr_d = lt_cnt_q;
    end else if (cmd_i.step_up) begin
      ptr_d = ptr_dec;
    end else if (cmd_i.scan_step || cmd_i.step_dn) begin
      ptr_d = ptr_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      ptr_q      <= '0;
      scan_vld_q <= 1'b0;
      wr_pend_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      count_q    <= count_d;
      ptr_q      <= ptr_d;
      scan_vld_q <= cmd_i.scan_step;
      wr_pend_q  <= cmd_i.step_up | cmd_i.step_dn;
      done_q     <= cmd_i.respond;
    end
  end

  // item capture, scan accumulation, move target
  always_ff @(posedge clk_i) begin
    if (cmd_i.step_up || cmd_i.step_dn) begin
      wr_idx_q <= ptr_q[IdxW-1:0];
    end
    if (cmd_i.load) begin
      func_q      <= func_i;
      addr_q      <= address_i;
      hit_q       <= hit_flag_i;
      create_q    <= create_if_missing_i;
      lt_cnt_q    <= '0;
      eq_q        <= 1'b0;
      floor_vld_q <= 1'b0;
    end else if (scan_vld_q) begin
      // sorted entries: count of smaller ones is the insert / match position
      if (rd_addr < addr_q) begin
        lt_cnt_q <= lt_cnt_q + CntW'(1);
      end
      if (rd_addr == addr_q) begin
        eq_q <= 1'b1;
      end
      if (rd_addr <= addr_q) begin
        floor_vld_q  <= 1'b1;
        floor_addr_q <= rd_addr;
        floor_hit_q  <= rd_hit;
      end
    end
  end

  always_comb begin
    found_d = 1'b0;
    if (func_q == sbt_pkg::FUNC_NEAREST) begin
      found_d = floor_vld_q;
    end else if (func_q == sbt_pkg::FUNC_SET || func_q == sbt_pkg::FUNC_UNSET) begin
      found_d = eq_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.respond) begin
      found_q      <= found_d;
      status_q     <= cmd_i.refused;
      entry_addr_q <= '0;
      entry_hit_q  <= 1'b0;
      if (func_q == sbt_pkg::FUNC_NEAREST && floor_vld_q) begin
        entry_addr_q <= floor_addr_q;
        entry_hit_q  <= floor_hit_q;
      end
    end
  end

  assign stat_o.func      = func_q;
  assign stat_o.create    = create_q;
  assign stat_o.eq        = eq_q;
  assign stat_o.full      = (count_q == CntW'(MaxEntries));
  assign stat_o.scan_end  = (ptr_q == count_q);
  assign stat_o.up_end    = (ptr_q == lt_cnt_q);
  assign stat_o.dn_end    = (ptr_inc == count_q);
  assign stat_o.pipe_busy = scan_vld_q | wr_pend_q;

  assign done_o          = done_q;
  assign found_o         = found_q;
  assign entry_address_o = entry_addr_q;
  assign entry_hit_o     = entry_hit_q;
  assign status_o        = status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxEntries))
    else $error("entry count above capacity");

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_new |-> (count_q < CntW'(MaxEntries)))
    else $error("insert into full table");

  a_remove_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.dec_count |-> (count_q != '0))
    else $error("remove from empty table");

  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_new |-> !wr_pend_q)
    else $error("new entry write collides with pending move");

  a_single_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("two results in consecutive cycles");

endmodule

// ===== src/sorted_breakpoint_table.sv =====
// Top level of the sorted breakpoint table: controller plus datapath.
//
//   channel   direction  handshake               fields
//   command   in         start_i && !busy_o      func_i address_i hit_flag_i
//                                                create_if_missing_i
//   result    out        done_o (one cycle)      found_o entry_address_o
//                                                entry_hit_o status_o
//
// Flow: entries sit in one memory and are scanned one per cycle; an insert
// or remove then adds one move per shifted entry (at most N with N stored
// entries) before the result is issued. The memory read port sets the rate.
// Reset: rst_ni low empties the table (count cleared); entry contents are
// not cleared and need no clearing pass.
// Stalls: busy_o stays high from accept until the result is issued; done_o
// is a one-cycle strobe and the receiver cannot hold it off.
module sorted_breakpoint_table #(
  parameter int MaxEntries = sbt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [sbt_pkg::FUNC_W-1:0] func_i,
  input  logic [sbt_pkg::ADDR_W-1:0] address_i,
  input  logic                       hit_flag_i,
  input  logic                       create_if_missing_i,
  output logic                       done_o,
  output logic                       found_o,
  output logic [sbt_pkg::ADDR_W-1:0] entry_address_o,
  output logic                       entry_hit_o,
  output logic                       status_o
);

  sbt_pkg::sbt_cmd_t  cmd;
  sbt_pkg::sbt_stat_t stat;

  // controller only sees start while idle, so start && !busy is the accept
  sbt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  sbt_datapath #(
    .MaxEntries (MaxEntries)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .func_i              (func_i),
    .address_i           (address_i),
    .hit_flag_i          (hit_flag_i),
    .create_if_missing_i (create_if_missing_i),
    .done_o              (done_o),
    .found_o             (found_o),
    .entry_address_o     (entry_address_o),
    .entry_hit_o         (entry_hit_o),
    .status_o            (status_o)
  );

endmodule

// ===== verif/testbench.sv =====
// Randomized and directed test of the sorted breakpoint table against a mirror of its entries.
`timescale 1ns / 1ps

// Status codes carried on status_o.
localparam logic STAT_DONE = 1'b0;
localparam logic STAT_FULL = 1'b1;

// One command item as driven on the command ports.
typedef struct packed {
  logic [sbt_pkg::FUNC_W-1:0] func;
  logic [sbt_pkg::ADDR_W-1:0] addr;
  logic                       hit;
  logic                       create;
} request_t;

// One result item as seen on the result ports.
typedef struct packed {
  logic                       found;
  logic [sbt_pkg::ADDR_W-1:0] addr;
  logic                       hit;
  logic                       status;
} answer_t;

// Scoreboard: keeps a sorted mirror of the table and the answers still owed.
class bp_scoreboard;
  logic [sbt_pkg::ADDR_W-1:0] mirror_addr [sbt_pkg::MAX_ENTRIES_DEF];
  logic                       mirror_hit  [sbt_pkg::MAX_ENTRIES_DEF];
  int unsigned                mirror_count;
  answer_t                    answers_due [$];
  int unsigned errors, answers_seen, commands;
  int unsigned inserts, removes, floor_hits, floor_misses, refusals, peak_count;

  // Applies one command to the mirror and returns the answer it owes.
  function answer_t mirror_answer(request_t r);
    answer_t     a;
    int unsigned at;
    int unsigned below;
    int unsigned floor_n;
    a        = '0;
    a.status = STAT_DONE;
    at = mirror_count;
    for (int unsigned i = 0; i < mirror_count; i++)
      if (mirror_addr[i] == r.addr) at = i;
    case (r.func)
      sbt_pkg::FUNC_SET: begin
        if (at < mirror_count) begin
          a.found = 1'b1;
        end else if (r.create) begin
          if (mirror_count >= sbt_pkg::MAX_ENTRIES_DEF) begin
            a.status = STAT_FULL;
            refusals++;
          end else begin
            below = 0;
            for (int unsigned i = 0; i < mirror_count; i++)
              if (mirror_addr[i] < r.addr) below++;
            for (int unsigned i = mirror_count; i > below; i--) begin
              mirror_addr[i] = mirror_addr[i-1];
              mirror_hit[i]  = mirror_hit[i-1];
            end
            mirror_addr[below] = r.addr;
            mirror_hit[below]  = r.hit;
            mirror_count++;
            inserts++;
            if (mirror_count > peak_count) peak_count = mirror_count;
          end
        end
      end
      sbt_pkg::FUNC_UNSET: begin
        if (at < mirror_count) begin
          a.found = 1'b1;
          for (int unsigned i = at; i + 1 < mirror_count; i++) begin
            mirror_addr[i] = mirror_addr[i+1];
            mirror_hit[i]  = mirror_hit[i+1];
          end
          mirror_count--;
          removes++;
        end
      end
      sbt_pkg::FUNC_NEAREST: begin
        // sorted, so the floor is the last entry not above the query
        floor_n = 0;
        for (int unsigned i = 0; i < mirror_count; i++)
          if (mirror_addr[i] <= r.addr) floor_n = i + 1;
        if (floor_n > 0) begin
          a.found = 1'b1;
          a.addr  = mirror_addr[floor_n-1];
          a.hit   = mirror_hit[floor_n-1];
          floor_hits++;
        end else begin
          floor_misses++;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  function void accept_cmd(request_t r);
    answer_t due;
    commands++;
    due = mirror_answer(r);
    answers_due.insert(answers_due.size(), due);
  endfunction

  task report(string what);
    errors++;
    // log stays short on a badly broken build; the count keeps going
    if (errors <= 40) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task check_answer(answer_t got);
    answer_t want;
    answers_seen++;
    if (answers_due.size() == 0) begin
      report($sformatf("result with nothing outstanding (found=%0b addr=%h)",
                       got.found, got.addr));
      return;
    end
    want = answers_due.pop_front();
    if (got.found !== want.found)
      report($sformatf("found %0b, expected %0b", got.found, want.found));
    if (got.addr !== want.addr)
      report($sformatf("entry_address %h, expected %h", got.addr, want.addr));
    if (got.hit !== want.hit)
      report($sformatf("entry_hit %0b, expected %0b", got.hit, want.hit));
    if (got.status !== want.status)
      report($sformatf("status %0b, expected %0b", got.status, want.status));
  endtask
endclass

module testbench;

  // Selector code the block leaves unused: no change, all-zero answer.
  localparam logic [sbt_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;
  // Watchdog limit on the length of the whole run; it leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int unsigned POOL_SIZE   = 24;
  localparam int unsigned PHASE_ITEMS = 470;

  typedef enum int {LEAN_FILL, LEAN_DRAIN, LEAN_EVEN} lean_e;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic [sbt_pkg::FUNC_W-1:0] func_i;
  logic [sbt_pkg::ADDR_W-1:0] address_i;
  logic                       hit_flag_i;
  logic                       create_if_missing_i;
  logic                       done_o;
  logic                       found_o;
  logic [sbt_pkg::ADDR_W-1:0] entry_address_o;
  logic                       entry_hit_o;
  logic                       status_o;

  bp_scoreboard               book;
  int unsigned                cycles = 0;
  logic [sbt_pkg::ADDR_W-1:0] addr_pool [POOL_SIZE];

  sorted_breakpoint_table #(
    .MaxEntries(sbt_pkg::MAX_ENTRIES_DEF)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .func_i             (func_i),
    .address_i          (address_i),
    .hit_flag_i         (hit_flag_i),
    .create_if_missing_i(create_if_missing_i),
    .done_o             (done_o),
    .found_o            (found_o),
    .entry_address_o    (entry_address_o),
    .entry_hit_o        (entry_hit_o),
    .status_o           (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung block ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               book.answers_due.size());
      $display("sorted_breakpoint_table test failed");
      $finish;
    end
  end

  // Result monitor: done_o is a one-cycle strobe, sampled at the edge ending it.
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      book.check_answer(answer_t'{found_o, entry_address_o, entry_hit_o, status_o});
  end

  function automatic request_t cmd(logic [sbt_pkg::FUNC_W-1:0] f,
                                   logic [sbt_pkg::ADDR_W-1:0] a,
                                   logic h, logic c);
    return request_t'{f, a, h, c};
  endfunction

  // Presents one item after an optional random gap and returns at the edge that
  // takes it. start_i stays high so a back-to-back item needs no re-raise.
  task automatic issue(request_t r, int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start_i             <= 1'b0;
      func_i              <= sbt_pkg::FUNC_W'($urandom());  // junk while idle
      address_i           <= $urandom();
      hit_flag_i          <= 1'($urandom());
      create_if_missing_i <= 1'($urandom());
    end
    @(negedge clk_i);
    start_i             <= 1'b1;
    func_i              <= r.func;
    address_i           <= r.addr;
    hit_flag_i          <= r.hit;
    create_if_missing_i <= r.create;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    book.accept_cmd(r);
  endtask

  // Holds off new items until every owed answer is back.
  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (book.answers_due.size() != 0) @(posedge clk_i);
  endtask

  // Pool: a cluster of near neighbors plus scattered values and both extremes;
  // more than the table depth so a fill lean can reach full.
  task automatic refill_pool();
    logic [sbt_pkg::ADDR_W-1:0] base;
    base = $urandom();
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int unsigned i = 2; i < POOL_SIZE; i++)
      addr_pool[i] = (i < 14) ? base + $urandom_range(40) : $urandom();
  endtask

  function automatic logic [sbt_pkg::ADDR_W-1:0] pick_addr();
    int unsigned roll;
    logic [sbt_pkg::ADDR_W-1:0] a;
    roll = $urandom_range(99);
    a    = addr_pool[$urandom_range(POOL_SIZE-1)];
    if (roll < 65) return a;
    if (roll < 80) return $urandom_range(1) ? a + 1 : a - 1;  // floor boundaries
    return $urandom();
  endfunction

  task automatic random_phase(int unsigned n, int unsigned idle_pct);
    lean_e       lean;
    request_t    r;
    int unsigned roll;
    int unsigned set_lim;
    int unsigned unset_lim;
    lean = LEAN_EVEN;
    refill_pool();
    for (int unsigned k = 0; k < n; k++) begin
      // bias shifts every few dozen items so fill level swings empty to full
      if (k % 30 == 0) lean = lean_e'($urandom_range(2));
      case (lean)
        LEAN_FILL:  begin set_lim = 60; unset_lim = 72; end
        LEAN_DRAIN: begin set_lim = 15; unset_lim = 70; end
        default:    begin set_lim = 35; unset_lim = 65; end
      endcase
      roll = $urandom_range(99);
      if (roll < set_lim)        r.func = sbt_pkg::FUNC_SET;
      else if (roll < unset_lim) r.func = sbt_pkg::FUNC_UNSET;
      else if (roll < 98)        r.func = sbt_pkg::FUNC_NEAREST;
      else                       r.func = FUNC_NONE;
      r.addr   = pick_addr();
      r.hit    = 1'($urandom());
      r.create = ($urandom_range(99) < 85);
      issue(r, idle_pct);
    end
  endtask

  task automatic directed();
    issue(cmd(sbt_pkg::FUNC_NEAREST, 32'h0000_0000, 1'b0, 1'b0), 0);  // lookup, empty
    issue(cmd(sbt_pkg::FUNC_UNSET,   32'h1234_5678, 1'b1, 1'b1), 0);  // unset missing
    issue(cmd(sbt_pkg::FUNC_SET,     32'h8000_0000, 1'b1, 1'b0), 0);  // no create
    issue(cmd(sbt_pkg::FUNC_SET,     32'h8000_0000, 1'b1, 1'b1), 0);  // insert
    issue(cmd(sbt_pkg::FUNC_SET,     32'h8000_0000, 1'b0, 1'b1), 0);  // present: flag kept
    issue(cmd(sbt_pkg::FUNC_NEAREST, 32'h7FFF_FFFF, 1'b0, 1'b0), 0);  // below every entry
    issue(cmd(sbt_pkg::FUNC_NEAREST, 32'h8000_0000, 1'b0, 1'b0), 0);  // exact hit
    issue(cmd(sbt_pkg::FUNC_SET,     32'h0000_0000, 1'b0, 1'b1), 0);  // lowest address
    issue(cmd(sbt_pkg::FUNC_SET,     32'hFFFF_FFFF, 1'b1, 1'b1), 0);  // highest address
    issue(cmd(sbt_pkg::FUNC_NEAREST, 32'h0000_0000, 1'b1, 1'b1), 0);
    issue(cmd(sbt_pkg::FUNC_NEAREST, 32'hFFFF_FFFF, 1'b1, 1'b1), 0);
    issue(cmd(FUNC_NONE,             32'hFFFF_FFFF, 1'b1, 1'b1), 0);  // unused selector
    // fill to capacity with alternating hit flags
    for (int unsigned i = 0; i < sbt_pkg::MAX_ENTRIES_DEF - 3; i++)
      issue(cmd(sbt_pkg::FUNC_SET, 32'h0100_0000 + i * 32'h0A00_0003, i[0], 1'b1), 0);
    issue(cmd(sbt_pkg::FUNC_SET,     32'h4444_4444, 1'b1, 1'b1), 0);  // full: refused
    issue(cmd(sbt_pkg::FUNC_SET,     32'h8000_0000, 1'b1, 1'b1), 0);  // full, present
    issue(cmd(sbt_pkg::FUNC_UNSET,   32'h8000_0000, 1'b0, 1'b0), 0);  // remove second to last
    issue(cmd(sbt_pkg::FUNC_UNSET,   32'h0000_0000, 1'b0, 1'b0), 0);  // remove first
    issue(cmd(sbt_pkg::FUNC_UNSET,   32'hFFFF_FFFF, 1'b0, 1'b0), 0);  // remove last
  endtask

  initial begin
    book                = new();
    rst_ni              = 1'b0;
    start_i             = 1'b0;
    func_i              = sbt_pkg::FUNC_NEAREST;
    address_i           = '0;
    hit_flag_i          = 1'b0;
    create_if_missing_i = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    directed();
    drain();  // sender waits for every answer before the random part
    random_phase(PHASE_ITEMS, 16);
    drain();
    random_phase(PHASE_ITEMS, 74);
    drain();
    random_phase(PHASE_ITEMS, 0);

    drain();
    repeat (60) @(posedge clk_i);

    $display("covered %0d items, %0d results: %0d inserts, %0d removes, %0d full refusals",
             book.commands, book.answers_seen, book.inserts, book.removes, book.refusals);
    $display("floor lookups %0d found / %0d not found, peak fill %0d, %0d mismatches",
             book.floor_hits, book.floor_misses, book.peak_count, book.errors);
    if (book.errors == 0 && book.answers_due.size() == 0) begin
      $display("sorted_breakpoint_table test passed");
    end else begin
      $display("sorted_breakpoint_table test failed");
    end
    $finish;
  end

endmodule
